// ===== design/eoe_frt_pkg.sv =====
// ----------------------------------------------------------------------------
// EoE fragment reassembly tracker package
// Shared types and constants for the fragment tracker core and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package eoe_frt_pkg;

    localparam int unsigned SIZE_W    = 16;
    localparam int unsigned MBX_W     = 4;
    localparam int unsigned FRAG_W    = 6;
    localparam int unsigned UNITS_W   = 6;
    localparam int unsigned FRAME_W   = 4;
    localparam int unsigned EXPECT_W  = 8;
    localparam int unsigned UNIT_SHIFT = 5;

    localparam logic [SIZE_W-1:0] TIMESTAMP_BYTES   = 16'd4;
    localparam logic [SIZE_W-1:0] CAPACITY_RESET    = 16'd1536;
    localparam logic [MBX_W-1:0]  EOE_TYPE_RESET    = 4'h2;

    typedef enum logic [1:0] {
        ST_PROGRESS = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_INVALID  = 2'd2,
        ST_PKT_ERR  = 2'd3
    } status_t;

    typedef enum logic {
        CFG_BUFFER_CAPACITY = 1'b0,
        CFG_EOE_MAILBOX_TYPE = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [SIZE_W-1:0] buffer_capacity;
        logic [MBX_W-1:0]  eoe_mailbox_type;
    } cfg_t;

    typedef struct packed {
        logic [MBX_W-1:0]   mailbox_type;
        logic [SIZE_W-1:0]  data_size;
        logic [FRAG_W-1:0]  fragment_number;
        logic [UNITS_W-1:0] offset_units;
        logic [FRAME_W-1:0] frame_number;
        logic               last_fragment;
        logic               time_appended;
    } item_t;

    typedef struct packed {
        status_t           status;
        logic              write_enable;
        logic [SIZE_W-1:0] write_offset;
        logic [SIZE_W-1:0] frame_length;
    } result_t;

endpackage

`default_nettype wire

// ===== design/eoe_frt_core.sv =====
// ----------------------------------------------------------------------------
// EoE fragment tracker core
// Holds the reassembly state and evaluates one fragment header per cycle in which step is high.
// ----------------------------------------------------------------------------
`default_nettype none

module eoe_frt_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire eoe_frt_pkg::cfg_t     cfg,
    input  wire eoe_frt_pkg::item_t    item,
    output eoe_frt_pkg::result_t       result
);

    logic [eoe_frt_pkg::EXPECT_W-1:0] expected_reg, expected_next;
    logic [eoe_frt_pkg::SIZE_W-1:0]   announced_reg, announced_next;
    logic [eoe_frt_pkg::SIZE_W-1:0]   fill_reg, fill_next;
    logic [eoe_frt_pkg::FRAME_W-1:0]  frame_reg, frame_next;

    logic [eoe_frt_pkg::EXPECT_W-1:0] frag_ext;
    logic [eoe_frt_pkg::SIZE_W-1:0]   units_bytes;
    logic [eoe_frt_pkg::SIZE_W:0]     end_sum;
    logic [eoe_frt_pkg::SIZE_W-1:0]   flen;
    logic                             mismatch;
    logic                             fits;

    assign frag_ext    = {{(eoe_frt_pkg::EXPECT_W - eoe_frt_pkg::FRAG_W){1'b0}},
                          item.fragment_number};
    assign units_bytes = {{(eoe_frt_pkg::SIZE_W - eoe_frt_pkg::UNITS_W
                            - eoe_frt_pkg::UNIT_SHIFT){1'b0}},
                          item.offset_units, {eoe_frt_pkg::UNIT_SHIFT{1'b0}}};
    assign mismatch    = (expected_reg != frag_ext);

    always_comb
    begin
        expected_next       = expected_reg;
        announced_next      = announced_reg;
        fill_next           = fill_reg;
        frame_next          = frame_reg;
        result.status       = eoe_frt_pkg::ST_PROGRESS;
        result.write_enable = 1'b0;
        result.write_offset = '0;
        result.frame_length = '0;
        end_sum             = '0;
        fits                = 1'b0;
        flen                = '0;

        if (item.mailbox_type != cfg.eoe_mailbox_type)
        begin
            result.status = eoe_frt_pkg::ST_PKT_ERR;
        end
        else
        begin
            if (mismatch && (expected_reg != '0))
            begin
                expected_next  = '0;
                announced_next = '0;
                fill_next      = '0;
                frame_next     = '0;
            end

            if (mismatch && (item.fragment_number != '0))
            begin
                result.status = eoe_frt_pkg::ST_INVALID;
            end
            else if (!mismatch && (expected_reg != '0) &&
                     ((frame_reg != item.frame_number) || (fill_reg != units_bytes)))
            begin
                expected_next  = '0;
                announced_next = '0;
                fill_next      = '0;
                frame_next     = '0;
                result.status  = eoe_frt_pkg::ST_INVALID;
            end
            else
            begin
                if (mismatch || (expected_reg == '0))
                begin
                    announced_next = units_bytes;
                    fill_next      = '0;
                    frame_next     = item.frame_number;
                end

                end_sum = {1'b0, fill_next} + {1'b0, item.data_size};
                fits    = (end_sum <= {1'b0, announced_next}) &&
                          (end_sum <= {1'b0, cfg.buffer_capacity});

                if (fits)
                begin
                    result.write_enable = 1'b1;
                    result.write_offset = fill_next;
                    fill_next           = end_sum[eoe_frt_pkg::SIZE_W-1:0];
                    expected_next       = expected_next + eoe_frt_pkg::EXPECT_W'(1);
                end

                if (item.last_fragment)
                begin
                    flen = item.time_appended ? (fill_next - eoe_frt_pkg::TIMESTAMP_BYTES)
                                              : fill_next;
                    result.frame_length = flen;
                    result.status       = eoe_frt_pkg::ST_COMPLETE;
                    expected_next       = '0;
                    announced_next      = '0;
                    fill_next           = '0;
                    frame_next          = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg  <= '0;
            announced_reg <= '0;
            fill_reg      <= '0;
            frame_reg     <= '0;
        end
        else if (step)
        begin
            expected_reg  <= expected_next;
            announced_reg <= announced_next;
            fill_reg      <= fill_next;
            frame_reg     <= frame_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/eoe_fragment_reassembly_tracker.sv =====
// Pipeline: a header accepted into the input register is evaluated by the core and presented
// from the result register once the output can advance (input register, then result register).
// Throughput: one header per cycle while the output is not stalled; the core's state update sets the rate.
// Reset: rst_n clears the reassembly state and the valid flags, and loads the
// buffer capacity with 1536 and the EoE mailbox type with 2.
// ----------------------------------------------------------------------------
// EoE fragment reassembly tracker
// Checks EoE fragment headers and tracks the write offset of one frame.
// ----------------------------------------------------------------------------
`default_nettype none

module eoe_fragment_reassembly_tracker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                cfg_write,
    input  wire logic                                cfg_index,
    input  wire logic [eoe_frt_pkg::SIZE_W-1:0]      cfg_data,

    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [eoe_frt_pkg::MBX_W-1:0]       mailbox_type,
    input  wire logic [eoe_frt_pkg::SIZE_W-1:0]      data_size,
    input  wire logic [eoe_frt_pkg::FRAG_W-1:0]      fragment_number,
    input  wire logic [eoe_frt_pkg::UNITS_W-1:0]     offset_units,
    input  wire logic [eoe_frt_pkg::FRAME_W-1:0]     frame_number,
    input  wire logic                                last_fragment,
    input  wire logic                                time_appended,

    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [1:0]                               status,
    output logic                                     write_enable,
    output logic [eoe_frt_pkg::SIZE_W-1:0]           write_offset,
    output logic [eoe_frt_pkg::SIZE_W-1:0]           frame_length
);

    eoe_frt_pkg::cfg_t    cfg_reg;
    eoe_frt_pkg::item_t   item_reg;
    eoe_frt_pkg::result_t result_reg;
    eoe_frt_pkg::result_t result_next;
    logic                 item_valid_reg;
    logic                 out_valid_reg;
    logic                 advance;
    logic                 step;
    logic                 in_accept;

    assign advance   = !out_valid_reg || !out_stall;
    assign step      = item_valid_reg && advance;
    assign in_stall  = item_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.buffer_capacity  <= eoe_frt_pkg::CAPACITY_RESET;
            cfg_reg.eoe_mailbox_type <= eoe_frt_pkg::EOE_TYPE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (eoe_frt_pkg::cfg_index_t'(cfg_index))
                eoe_frt_pkg::CFG_BUFFER_CAPACITY:
                    cfg_reg.buffer_capacity <= cfg_data;
                eoe_frt_pkg::CFG_EOE_MAILBOX_TYPE:
                    cfg_reg.eoe_mailbox_type <= cfg_data[eoe_frt_pkg::MBX_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_accept)
                item_valid_reg <= 1'b1;
            else if (step)
                item_valid_reg <= 1'b0;

            if (step)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.mailbox_type    <= mailbox_type;
            item_reg.data_size       <= data_size;
            item_reg.fragment_number <= fragment_number;
            item_reg.offset_units    <= offset_units;
            item_reg.frame_number    <= frame_number;
            item_reg.last_fragment   <= last_fragment;
            item_reg.time_appended   <= time_appended;
        end
        if (step)
            result_reg <= result_next;
    end

    eoe_frt_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .cfg    (cfg_reg),
        .item   (item_reg),
        .result (result_next)
    );

    assign out_valid    = out_valid_reg;
    assign status       = result_reg.status;
    assign write_enable = result_reg.write_enable;
    assign write_offset = result_reg.write_offset;
    assign frame_length = result_reg.frame_length;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// EoE fragment reassembly tracker testbench
// Sends unpacked fragment headers through the valid/stall port, runs the
// reassembly rules in a scoreboard alongside the block and compares every
// reported transaction field by field. Covers directed corner cases, then
// random frames with injected flaws under several register settings, with
// bursty input and a varying output stall pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {
        FLAW_NONE,
        FLAW_MAILBOX,
        FLAW_FRAME,
        FLAW_OFFSET,
        FLAW_SEQUENCE,
        FLAW_SIZE,
        FLAW_EARLY_END
    } flaw_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    class reassembly_scoreboard;
        logic [eoe_frt_pkg::SIZE_W-1:0]   capacity;
        logic [eoe_frt_pkg::MBX_W-1:0]    eoe_type;
        logic [eoe_frt_pkg::EXPECT_W-1:0] expected_frag;
        logic [eoe_frt_pkg::SIZE_W-1:0]   announced;
        logic [eoe_frt_pkg::SIZE_W-1:0]   fill;
        logic [eoe_frt_pkg::FRAME_W-1:0]  cur_frame;
        eoe_frt_pkg::result_t             predicted_reports[$];
        int unsigned                      errors;

        function new();
            capacity = eoe_frt_pkg::CAPACITY_RESET;
            eoe_type = eoe_frt_pkg::EOE_TYPE_RESET;
            errors = 0;
            drop_frame();
        endfunction

        function void drop_frame();
            expected_frag = '0;
            announced = '0;
            fill = '0;
            cur_frame = '0;
        endfunction

        function void set_register(eoe_frt_pkg::cfg_index_t idx,
                                   logic [eoe_frt_pkg::SIZE_W-1:0] value);
            case (idx)
                eoe_frt_pkg::CFG_BUFFER_CAPACITY:  capacity = value;
                eoe_frt_pkg::CFG_EOE_MAILBOX_TYPE: eoe_type = value[eoe_frt_pkg::MBX_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_header(eoe_frt_pkg::item_t h);
            eoe_frt_pkg::result_t           r;
            logic [eoe_frt_pkg::SIZE_W:0]   fill_end;
            logic [eoe_frt_pkg::SIZE_W-1:0] slot_offset;
            r.status = eoe_frt_pkg::ST_PROGRESS;
            r.write_enable = 1'b0;
            r.write_offset = '0;
            r.frame_length = '0;
            slot_offset = {5'b0, h.offset_units, 5'b0};
            if (h.mailbox_type != eoe_type) begin
                r.status = eoe_frt_pkg::ST_PKT_ERR;
                predicted_reports.push_back(r);
                return;
            end
            if (expected_frag != {2'b00, h.fragment_number}) begin
                if (expected_frag != '0)
                    drop_frame();
                if (h.fragment_number != '0) begin
                    r.status = eoe_frt_pkg::ST_INVALID;
                    predicted_reports.push_back(r);
                    return;
                end
            end
            if (expected_frag == '0) begin
                announced = slot_offset;
                fill = '0;
                cur_frame = h.frame_number;
            end
            else if (cur_frame != h.frame_number || fill != slot_offset) begin
                drop_frame();
                r.status = eoe_frt_pkg::ST_INVALID;
                predicted_reports.push_back(r);
                return;
            end
            fill_end = {1'b0, fill} + {1'b0, h.data_size};
            if (fill_end <= {1'b0, announced} && fill_end <= {1'b0, capacity}) begin
                r.write_enable = 1'b1;
                r.write_offset = fill;
                fill = fill_end[eoe_frt_pkg::SIZE_W-1:0];
                expected_frag = expected_frag + 8'd1;
            end
            if (h.last_fragment) begin
                r.frame_length = h.time_appended ? fill - eoe_frt_pkg::TIMESTAMP_BYTES : fill;
                r.status = eoe_frt_pkg::ST_COMPLETE;
                drop_frame();
            end
            predicted_reports.push_back(r);
        endfunction

        function void check_result(eoe_frt_pkg::result_t got);
            eoe_frt_pkg::result_t want;
            if (predicted_reports.size() == 0) begin
                $error("unexpected transaction: status %0d", got.status);
                errors++;
                return;
            end
            want = predicted_reports.pop_front();
            if (got.status != want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.write_enable != want.write_enable) begin
                $error("write_enable: expected %0d, got %0d",
                       want.write_enable, got.write_enable);
                errors++;
            end
            if (got.write_offset != want.write_offset) begin
                $error("write_offset: expected %0d, got %0d",
                       want.write_offset, got.write_offset);
                errors++;
            end
            if (got.frame_length != want.frame_length) begin
                $error("frame_length: expected %0d, got %0d",
                       want.frame_length, got.frame_length);
                errors++;
            end
        endfunction

        function int pending();
            return predicted_reports.size();
        endfunction
    endclass

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_write = 1'b0;
    logic                                cfg_index = 1'b0;
    logic [eoe_frt_pkg::SIZE_W-1:0]      cfg_data = '0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic [eoe_frt_pkg::MBX_W-1:0]       mailbox_type = '0;
    logic [eoe_frt_pkg::SIZE_W-1:0]      data_size = '0;
    logic [eoe_frt_pkg::FRAG_W-1:0]      fragment_number = '0;
    logic [eoe_frt_pkg::UNITS_W-1:0]     offset_units = '0;
    logic [eoe_frt_pkg::FRAME_W-1:0]     frame_number = '0;
    logic                                last_fragment = 1'b0;
    logic                                time_appended = 1'b0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic [1:0]                          status;
    logic                                write_enable;
    logic [eoe_frt_pkg::SIZE_W-1:0]      write_offset;
    logic [eoe_frt_pkg::SIZE_W-1:0]      frame_length;

    reassembly_scoreboard                sb;
    eoe_frt_pkg::result_t                seen;
    logic [eoe_frt_pkg::MBX_W-1:0]       eoe_type_cfg = eoe_frt_pkg::EOE_TYPE_RESET;
    int                                  burst_left = 0;
    int                                  items_sent = 0;
    int                                  cycles = 0;
    bit                                  hold_req = 1'b0;

    eoe_fragment_reassembly_tracker uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mailbox_type    (mailbox_type),
        .data_size       (data_size),
        .fragment_number (fragment_number),
        .offset_units    (offset_units),
        .frame_number    (frame_number),
        .last_fragment   (last_fragment),
        .time_appended   (time_appended),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .write_enable    (write_enable),
        .write_offset    (write_offset),
        .frame_length    (frame_length)
    );

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen.status = eoe_frt_pkg::status_t'(status);
            seen.write_enable = write_enable;
            seen.write_offset = write_offset;
            seen.frame_length = frame_length;
            sb.check_result(seen);
        end
    end

    // output side: long hold on request, otherwise a changing stall pattern
    initial
    begin
        int          hold_left;
        int          mode_left;
        stall_mode_t mode;
        hold_left = 0;
        mode_left = 0;
        mode = STALL_NONE;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = 300;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = stall_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(32, 256);
                end
                mode_left--;
                case (mode)
                    STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
                    STALL_PERIODIC: out_stall <= (cycles % 3 == 0);
                    default:        out_stall <= 1'b0;
                endcase
            end
        end
    end

    function automatic eoe_frt_pkg::item_t make_header(
        logic [eoe_frt_pkg::MBX_W-1:0]   mbx,
        logic [eoe_frt_pkg::SIZE_W-1:0]  dsize,
        logic [eoe_frt_pkg::FRAG_W-1:0]  frag,
        logic [eoe_frt_pkg::UNITS_W-1:0] units,
        logic [eoe_frt_pkg::FRAME_W-1:0] frame,
        logic                            last,
        logic                            ts);
        eoe_frt_pkg::item_t h;
        h.mailbox_type = mbx;
        h.data_size = dsize;
        h.fragment_number = frag;
        h.offset_units = units;
        h.frame_number = frame;
        h.last_fragment = last;
        h.time_appended = ts;
        return h;
    endfunction

    task automatic send_header(input eoe_frt_pkg::item_t h);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                      : $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        mailbox_type <= h.mailbox_type;
        data_size <= h.data_size;
        fragment_number <= h.fragment_number;
        offset_units <= h.offset_units;
        frame_number <= h.frame_number;
        last_fragment <= h.last_fragment;
        time_appended <= h.time_appended;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_header(h);
        items_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input eoe_frt_pkg::cfg_index_t idx,
                                  input logic [eoe_frt_pkg::SIZE_W-1:0] value);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_register(idx, value);
        if (idx == eoe_frt_pkg::CFG_EOE_MAILBOX_TYPE)
            eoe_type_cfg = value[eoe_frt_pkg::MBX_W-1:0];
    endtask

    task automatic send_noise();
        eoe_frt_pkg::item_t h;
        h.mailbox_type = $urandom_range(0, 1) ? eoe_type_cfg : 4'($urandom);
        h.data_size = 16'($urandom);
        h.fragment_number = 6'($urandom);
        h.offset_units = 6'($urandom);
        h.frame_number = 4'($urandom);
        h.last_fragment = 1'($urandom);
        h.time_appended = 1'($urandom);
        send_header(h);
    endtask

    task automatic send_frame();
        int                 units;
        int                 nfrag;
        int                 fill;
        int                 room;
        int                 dsize;
        logic [3:0]         fr;
        logic               ts;
        bit                 last;
        flaw_t              flaw;
        eoe_frt_pkg::item_t h;
        fr = 4'($urandom);
        ts = 1'($urandom);
        units = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 6);
        nfrag = $urandom_range(1, 4);
        fill = 0;
        for (int k = 0; k < nfrag; k++)
        begin
            last = (k == nfrag - 1);
            room = units * 32 - fill;
            if (room < 0)
                room = 0;
            dsize = last ? $urandom_range(0, room) : 32 * $urandom_range(0, room / 32);
            h = make_header(eoe_type_cfg, 16'(dsize), 6'(k),
                            6'((k == 0) ? units : fill / 32), fr, last, ts);
            flaw = ($urandom_range(0, 3) == 0) ? flaw_t'($urandom_range(1, 6)) : FLAW_NONE;
            case (flaw)
                FLAW_MAILBOX:  h.mailbox_type = h.mailbox_type ^ 4'($urandom_range(1, 15));
                FLAW_FRAME:    h.frame_number = h.frame_number ^ 4'(1 << $urandom_range(0, 3));
                FLAW_OFFSET:   h.offset_units = h.offset_units + 6'($urandom_range(1, 63));
                FLAW_SEQUENCE: h.fragment_number = 6'($urandom);
                FLAW_SIZE:     h.data_size = 16'($urandom);
                FLAW_EARLY_END:
                begin
                    h.last_fragment = 1'b1;
                    h.time_appended = 1'($urandom);
                end
                default: ;
            endcase
            send_header(h);
            fill += dsize;
        end
    endtask

    // run the fragment counter past 63 with empty fragments, then follow up
    task automatic send_long_frame(input logic [eoe_frt_pkg::FRAG_W-1:0] final_frag);
        logic [3:0] fr;
        fr = 4'($urandom);
        for (int k = 0; k < 64; k++)
            send_header(make_header(eoe_type_cfg, 16'd0, 6'(k),
                                    (k == 0) ? 6'($urandom) : 6'd0, fr, 1'b0, 1'b0));
        send_header(make_header(eoe_type_cfg, 16'd0, final_frag, 6'd0, fr, 1'b1, 1'b1));
    endtask

    task automatic run_traffic(input int budget);
        int start;
        start = items_sent;
        while (items_sent - start < budget)
        begin
            if ($urandom_range(0, 99) < 15)
                send_noise();
            else
                send_frame();
        end
    endtask

    task automatic run_directed();
        logic [3:0] t;
        t = eoe_type_cfg;
        send_header(make_header(4'hF, 16'hFFFF, 6'd63, 6'd63, 4'd15, 1'b1, 1'b1));
        send_header(make_header(t, 16'd0, 6'd0, 6'd0, 4'd0, 1'b0, 1'b0));
        send_header(make_header(t, 16'd0, 6'd5, 6'd0, 4'd0, 1'b0, 1'b0));
        send_header(make_header(t, 16'd32, 6'd0, 6'd2, 4'd15, 1'b0, 1'b0));
        send_header(make_header(t, 16'd32, 6'd1, 6'd1, 4'd15, 1'b1, 1'b1));
        send_header(make_header(t, 16'hFFFF, 6'd0, 6'd63, 4'd3, 1'b0, 1'b0));
        send_header(make_header(t, 16'd0, 6'd0, 6'd63, 4'd3, 1'b1, 1'b1));
        send_header(make_header(t, 16'd32, 6'd0, 6'd4, 4'd3, 1'b0, 1'b0));
        send_header(make_header(t, 16'd32, 6'd1, 6'd1, 4'd4, 1'b0, 1'b0));
        send_header(make_header(t, 16'd32, 6'd0, 6'd4, 4'd3, 1'b0, 1'b0));
        send_header(make_header(t, 16'd32, 6'd1, 6'd2, 4'd3, 1'b0, 1'b0));
        send_header(make_header(t, 16'd64, 6'd0, 6'd4, 4'd7, 1'b0, 1'b0));
        send_header(make_header(t, 16'd32, 6'd1, 6'd2, 4'd7, 1'b0, 1'b0));
        send_header(make_header(t, 16'd32, 6'd0, 6'd1, 4'd8, 1'b1, 1'b0));
        send_header(make_header(t, 16'd32, 6'd0, 6'd4, 4'd1, 1'b0, 1'b0));
        send_header(make_header(t, 16'd32, 6'd2, 6'd1, 4'd1, 1'b0, 1'b0));
        send_header(make_header(t, 16'd32, 6'd1, 6'd1, 4'd1, 1'b0, 1'b0));
        send_header(make_header(t, 16'd32, 6'd0, 6'd1, 4'd2, 1'b0, 1'b0));
        send_header(make_header(t, 16'd1, 6'd1, 6'd1, 4'd2, 1'b1, 1'b0));
        send_header(make_header(t, 16'd1536, 6'd0, 6'd63, 4'd9, 1'b0, 1'b0));
        send_header(make_header(t, 16'd1, 6'd1, 6'd48, 4'd9, 1'b1, 1'b0));
        send_header(make_header(t, 16'd64, 6'd0, 6'd63, 4'd5, 1'b0, 1'b0));
        send_header(make_header(t, 16'hFFFF, 6'd1, 6'd2, 4'd5, 1'b1, 1'b1));
    endtask

    initial
    begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        hold_req = 1'b1;
        run_traffic(250);

        write_register(eoe_frt_pkg::CFG_BUFFER_CAPACITY, 16'hFFFF);
        write_register(eoe_frt_pkg::CFG_EOE_MAILBOX_TYPE, 16'd15);
        run_traffic(220);
        send_long_frame(6'd0);

        write_register(eoe_frt_pkg::CFG_BUFFER_CAPACITY, 16'd0);
        write_register(eoe_frt_pkg::CFG_EOE_MAILBOX_TYPE, 16'd0);
        run_traffic(180);

        write_register(eoe_frt_pkg::CFG_BUFFER_CAPACITY, 16'd64);
        write_register(eoe_frt_pkg::CFG_EOE_MAILBOX_TYPE, 16'd2);
        run_traffic(200);

        write_register(eoe_frt_pkg::CFG_BUFFER_CAPACITY, 16'($urandom_range(0, 2100)));
        write_register(eoe_frt_pkg::CFG_EOE_MAILBOX_TYPE, 16'($urandom_range(0, 15)));
        run_traffic(200);
        send_long_frame(6'($urandom_range(1, 63)));

        write_register(eoe_frt_pkg::CFG_BUFFER_CAPACITY, eoe_frt_pkg::CAPACITY_RESET);
        write_register(eoe_frt_pkg::CFG_EOE_MAILBOX_TYPE, 16'(eoe_frt_pkg::EOE_TYPE_RESET));
        run_traffic(200);

        wait_idle();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

`default_nettype wire
